### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### rtl/rler_pkg.sv
// Package: types, constants and state codes of the longest-equal-run block.
package rler_pkg;
   localparam int MAX_ELEMS  = 1024;
   localparam int IDX_W      = $clog2(MAX_ELEMS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int TREE_AW    = IDX_W + 1;
   localparam int LEN_W      = 11;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic signed [31:0] value;
      logic [9:0]        left_index;
      logic [9:0]        right_index;
   } req_type;

   typedef struct packed {
      logic [10:0] longest_run;
      logic        bad_range;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_AP_LEAF,
      ST_AP_UP,
      ST_Q_RUN,
      ST_Q_START,
      ST_Q_C1,
      ST_Q_C2,
      ST_Q_TREE,
      ST_Q_ACC,
      ST_Q_DONE
   } state_type;
endpackage

### rtl/rler_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
module rler_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/range_longest_equal_run.sv
// Longest run of equal adjacent values within an index range, one item at a time.
// Append: leaf read and write, then one tree level a cycle; the next item waits until the walk ends.
// Query: a bad range goes straight to the result; when both ends share a run, the result
// follows the run lookups, else run-start reads, tree walk steps and node reads come first;
// then the block takes the next item. Clear: one tree entry zeroed a cycle; a waiting result delays only a query.
// Reset: synchronous; counts go to zero and a clearing pass over the tree runs before any item.
module range_longest_equal_run
   import rler_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   state_type state_ff, state_in;
   logic [31:0]        last_value_ff, last_value_in;
   logic [CNT_W-1:0]   elem_cnt_ff, elem_cnt_in;
   logic [CNT_W-1:0]   run_cnt_ff, run_cnt_in;
   logic [TREE_AW-1:0] ptr_ff, ptr_in;      // clear sweep / append walk
   logic [TREE_AW-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [IDX_W-1:0]   l_ff, l_in, r_ff, r_in;
   logic [IDX_W-1:0]   ra_ff, ra_in, rb_ff, rb_in;
   logic [LEN_W-1:0]   best_ff, best_in;
   logic [LEN_W-1:0]   cur_ff, cur_in;      // node value carried up the append walk
   logic               bad_ff, bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Memory ports
   logic               roe_we, rs_we, tr_we;
   logic [IDX_W-1:0]   roe_wa, roe_ra, rs_wa, rs_ra;
   logic [IDX_W-1:0]   roe_wd, roe_rd, rs_wd, rs_rd;
   logic [TREE_AW-1:0] tr_wa, tr_ra;
   logic [LEN_W-1:0]   tr_wd, tr_rd;

   rler_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMS)) u_run_of (
      .clock, .wr_en(roe_we), .wr_addr(roe_wa), .wr_data(roe_wd),
      .rd_addr(roe_ra), .rd_data(roe_rd));
   rler_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMS)) u_run_start (
      .clock, .wr_en(rs_we), .wr_addr(rs_wa), .wr_data(rs_wd),
      .rd_addr(rs_ra), .rd_data(rs_rd));
   rler_ram #(.WIDTH(LEN_W), .DEPTH(2*MAX_ELEMS)) u_tree (
      .clock, .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(tr_wd),
      .rd_addr(tr_ra), .rd_data(tr_rd));

   logic accept, new_run, out_free, ap_ok, q_bad;
   logic [IDX_W-1:0] cur_run;
   logic [LEN_W-1:0] c1, c2, up_max;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign new_run   = (elem_cnt_ff == '0) || ($unsigned(req_data.value) != last_value_ff);
   assign cur_run   = new_run ? run_cnt_ff[IDX_W-1:0] : IDX_W'(run_cnt_ff - 1'b1);
   assign ap_ok     = (elem_cnt_ff < CNT_W'(MAX_ELEMS));
   assign q_bad     = (req_data.left_index > req_data.right_index) ||
                      ({1'b0, req_data.right_index} >= elem_cnt_ff);
   assign c1     = LEN_W'(rs_rd) - LEN_W'(l_ff);
   assign c2     = LEN_W'(r_ff) - LEN_W'(rs_rd) + LEN_W'(1);
   assign up_max = (tr_rd > cur_ff) ? tr_rd : cur_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_CLEAR:  state_in = ST_CLEAR;
                  ACT_APPEND: if (ap_ok) state_in = ST_AP_LEAF;
                  ACT_QUERY:  state_in = q_bad ? ST_Q_DONE : ST_Q_RUN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR:   if (ptr_ff == '1) state_in = ST_IDLE;
         ST_AP_LEAF: state_in = ST_AP_UP;
         ST_AP_UP:   if ((ptr_ff >> 1) == TREE_AW'(1)) state_in = ST_IDLE;
         ST_Q_RUN:   state_in = ST_Q_START;
         ST_Q_START: state_in = (ra_ff == roe_rd) ? ST_Q_DONE : ST_Q_C1;
         ST_Q_C1:    state_in = ST_Q_C2;
         ST_Q_C2:    state_in = ST_Q_TREE;
         ST_Q_TREE: begin
            if (qa_ff >= qb_ff) state_in = ST_Q_DONE;
            else if (qa_ff[0] || qb_ff[0]) state_in = ST_Q_ACC;
         end
         ST_Q_ACC:   state_in = ST_Q_TREE;
         ST_Q_DONE:  if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      last_value_in = last_value_ff;
      elem_cnt_in   = elem_cnt_ff;
      run_cnt_in    = run_cnt_ff;
      ptr_in  = ptr_ff;  qa_in = qa_ff;  qb_in = qb_ff;
      l_in = l_ff;  r_in = r_ff;  ra_in = ra_ff;  rb_in = rb_ff;
      best_in = best_ff;  cur_in = cur_ff;  bad_in = bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      roe_we = 1'b0; roe_wa = elem_cnt_ff[IDX_W-1:0]; roe_wd = cur_run; roe_ra = l_ff;
      rs_we  = 1'b0; rs_wa = run_cnt_ff[IDX_W-1:0]; rs_wd = elem_cnt_ff[IDX_W-1:0];
      rs_ra  = ra_ff;
      tr_we  = 1'b0; tr_wa = ptr_ff; tr_wd = '0; tr_ra = ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_CLEAR: begin
                     last_value_in = '0; elem_cnt_in = '0; run_cnt_in = '0; ptr_in = '0;
                  end
                  ACT_APPEND: begin
                     if (ap_ok) begin
                        if (new_run) begin
                           rs_we = 1'b1;
                           run_cnt_in = run_cnt_ff + 1'b1;
                        end
                        roe_we = 1'b1;
                        ptr_in = {1'b1, cur_run};
                        tr_ra  = {1'b1, cur_run};
                        last_value_in = req_data.value;
                        elem_cnt_in = elem_cnt_ff + 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     l_in = req_data.left_index;
                     r_in = req_data.right_index;
                     roe_ra = req_data.left_index;
                     best_in = '0;
                     bad_in = q_bad;
                  end
                  default: ;
               endcase
            end
         end
         // Zero one tree entry a cycle
         ST_CLEAR: begin
            tr_we = 1'b1; tr_wd = '0;
            ptr_in = ptr_ff + 1'b1;
         end
         // Bump the leaf and fetch its sibling
         ST_AP_LEAF: begin
            tr_we = 1'b1; tr_wd = tr_rd + 1'b1;
            cur_in = tr_rd + 1'b1;
            tr_ra = ptr_ff ^ TREE_AW'(1);
         end
         // Write the parent and fetch the next sibling, one level a cycle
         ST_AP_UP: begin
            tr_we = 1'b1;
            tr_wa = ptr_ff >> 1;
            tr_wd = up_max;
            cur_in = up_max;
            ptr_in = ptr_ff >> 1;
            tr_ra = (ptr_ff >> 1) ^ TREE_AW'(1);
         end
         ST_Q_RUN: begin
            roe_ra = r_ff;
            ra_in = roe_rd;
         end
         // Both ends in one run give the range length; else fetch start of run a+1
         ST_Q_START: begin
            rb_in = roe_rd;
            best_in = LEN_W'(r_ff) - LEN_W'(l_ff) + LEN_W'(1);
            rs_ra = IDX_W'(ra_ff + 1'b1);
         end
         // Clip the left partial run and fetch start of run b
         ST_Q_C1: begin
            best_in = c1;
            rs_ra = rb_ff;
         end
         // Clip the right partial run and set up the walk over runs a+1..b-1
         ST_Q_C2: begin
            if (c2 > best_ff) best_in = c2;
            qa_in = {1'b1, IDX_W'(ra_ff + 1'b1)};
            qb_in = {1'b1, rb_ff};
         end
         // Walk the half-open node range up the tree
         ST_Q_TREE: begin
            if (qa_ff < qb_ff) begin
               if (qa_ff[0]) begin
                  tr_ra = qa_ff;
                  qa_in = qa_ff + 1'b1;
               end else if (qb_ff[0]) begin
                  tr_ra = qb_ff - 1'b1;
                  qb_in = qb_ff - 1'b1;
               end else begin
                  qa_in = qa_ff >> 1; qb_in = qb_ff >> 1;
               end
            end
         end
         ST_Q_ACC: begin
            if (tr_rd > best_ff) best_in = tr_rd;
         end
         // Hold until the output register is free
         ST_Q_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '{longest_run: best_ff, bad_range: bad_ff};
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         last_value_ff <= '0;
         elem_cnt_ff   <= '0;
         run_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         last_value_ff <= last_value_in;
         elem_cnt_ff   <= elem_cnt_in;
         run_cnt_ff    <= run_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      qa_ff <= qa_in; qb_ff <= qb_in;
      l_ff <= l_in; r_ff <= r_in; ra_ff <= ra_in; rb_ff <= rb_in;
      best_ff <= best_in; cur_ff <= cur_in; bad_ff <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

### rtl/rler_checker.sv
// Port-level checker for the longest-equal-run block, bound to the top level.
`include "assert_macros.svh"
module rler_checker
   import rler_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
             rsp_valid && $stable(rsp_data), "stalled result changed")
   `CHK_IMPL(a_bad_zero, clock, reset, rsp_valid && rsp_data.bad_range,
             rsp_data.longest_run == '0, "bad range with length")
   `CHK_IMPL(a_good_len, clock, reset, rsp_valid && !rsp_data.bad_range,
             rsp_data.longest_run != '0, "good range with zero length")
   `CHK_NEXT(a_busy_after, clock, reset,
             req_valid && !req_stall && req_data.action == ACT_CLEAR,
             req_stall, "clear not busy")
endmodule

bind range_longest_equal_run rler_checker u_rler_checker (.*);
